>>> rtl/gbp_pkg.sv
// ---------------------------------------------------------------------------
// gbp_pkg
// shared constants and types for the gshare branch predictor
// ---------------------------------------------------------------------------
package gbp_pkg;

  // default sizing
  localparam int TABLE_ENTRIES_DEF = 16384;
  localparam int INDEX_WIDTH_DEF   = 14;
  localparam int HISTORY_WIDTH_DEF = 32;

  // widest table slot the parameter range allows (1M entries)
  localparam int SLOT_MAX_W = 20;

  // input item action codes
  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  // qualification threshold on operand count
  localparam logic [7:0] MIN_OPS = 8'd2;

  // saturating counter limits
  localparam logic [1:0] CNT_MIN = 2'b00;
  localparam logic [1:0] CNT_MAX = 2'b11;

  // classified operation handed from front to back
  typedef struct packed {
    logic                  is_update;
    logic                  qual;
    logic                  taken;
    logic [SLOT_MAX_W-1:0] slot;
  } gbp_op_t;

endpackage

>>> rtl/gbp_if.sv
// ---------------------------------------------------------------------------
// gbp_if
// valid/ready channels for branch requests and prediction responses
// ---------------------------------------------------------------------------
interface gbp_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] branch_addr;
  logic        is_cond;
  logic        is_call_br;
  logic        is_ret_br;
  logic [7:0]  op_count;
  logic        outcome_taken;

  modport source (
    output valid, action, branch_addr, is_cond, is_call_br, is_ret_br,
           op_count, outcome_taken,
    input  ready
  );
  modport sink (
    input  valid, action, branch_addr, is_cond, is_call_br, is_ret_br,
           op_count, outcome_taken,
    output ready
  );
endinterface

interface gbp_resp_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source (output valid, predict_taken, input ready);
  modport sink   (input valid, predict_taken, output ready);
endinterface

>>> rtl/gbp_front.sv
// ---------------------------------------------------------------------------
// gbp_front
// accepts requests, qualifies them, forms the gshare index and table slot
// ---------------------------------------------------------------------------
module gbp_front #(
  parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_WIDTH   = gbp_pkg::INDEX_WIDTH_DEF,
  parameter int HISTORY_WIDTH = gbp_pkg::HISTORY_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gbp_req_if.sink          req,
  input  logic             clear_busy,
  input  logic             q_ready,
  output logic             push,
  output gbp_pkg::gbp_op_t push_op
);

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int SH = (HISTORY_WIDTH > INDEX_WIDTH) ? (HISTORY_WIDTH - INDEX_WIDTH) : 0;

  logic [HISTORY_WIDTH-1:0] history;
  logic [SW-1:0]            saved_slot;
  logic                     a_valid;
  logic                     a_update;
  logic                     a_qual;
  logic                     a_taken;
  logic [INDEX_WIDTH-1:0]   a_idx;
  logic [INDEX_WIDTH-1:0]   idx;
  logic [SW-1:0]            slot_calc;
  logic                     accept;
  logic                     qual;

  assign qual = req.is_cond && !req.is_call_br && !req.is_ret_br &&
                (req.op_count >= gbp_pkg::MIN_OPS);

  // low address bits xor top history bits
  assign idx = req.branch_addr[INDEX_WIDTH-1:0] ^ INDEX_WIDTH'(history >> SH);

  assign push      = a_valid && q_ready;
  assign req.ready = !clear_busy && (!a_valid || q_ready);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      saved_slot <= '0;
      a_valid    <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (push) begin
        a_valid <= 1'b0;
      end
      if (accept && req.action == gbp_pkg::ACT_RESOLVE) begin
        history <= {history[HISTORY_WIDTH-2:0], req.outcome_taken};
      end
      if (push && !a_update && a_qual) begin
        saved_slot <= slot_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_update <= (req.action == gbp_pkg::ACT_RESOLVE);
      a_qual   <= qual;
      a_taken  <= req.outcome_taken;
      a_idx    <= idx;
    end
  end

  // index to slot: index modulo table size
  generate
    if ((TABLE_ENTRIES >= (1 << INDEX_WIDTH)) ||
        ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0)) begin : gen_direct
      assign slot_calc = SW'(a_idx);
    end else begin : gen_recip
      // exact quotient by rounded-up reciprocal, then remainder
      localparam int L   = $clog2(TABLE_ENTRIES);
      localparam int S   = INDEX_WIDTH + L;
      localparam int MW  = INDEX_WIDTH + 2;
      localparam int PW  = INDEX_WIDTH + MW;
      localparam logic [63:0]   M64 = ((64'd1 << S) / 64'(TABLE_ENTRIES)) + 64'd1;
      localparam logic [MW-1:0] MC  = MW'(M64);
      localparam logic [INDEX_WIDTH-1:0] TC = INDEX_WIDTH'(TABLE_ENTRIES);

      logic [PW-1:0]          a_prod;
      logic [PW-S-1:0]        quo;
      logic [INDEX_WIDTH-1:0] quo_t;
      logic [INDEX_WIDTH-1:0] rem;

      always_ff @(posedge clk) begin
        if (accept) begin
          a_prod <= PW'(idx) * PW'(MC);
        end
      end

      assign quo       = a_prod[PW-1:S];
      assign quo_t     = INDEX_WIDTH'(quo) * TC;
      assign rem       = a_idx - quo_t;
      assign slot_calc = SW'(rem);
    end
  endgenerate

  always_comb begin
    push_op           = '0;
    push_op.is_update = a_update;
    push_op.qual      = a_qual;
    push_op.taken     = a_taken;
    push_op.slot      = gbp_pkg::SLOT_MAX_W'(a_update ? saved_slot : slot_calc);
  end

endmodule

>>> rtl/gbp_queue.sv
// ---------------------------------------------------------------------------
// gbp_queue
// short fifo of classified operations between front and back
// ---------------------------------------------------------------------------
module gbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gbp_pkg::gbp_op_t push_op,
  output logic             q_ready,
  output logic             q_valid,
  output gbp_pkg::gbp_op_t q_op,
  input  logic             pop
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  gbp_pkg::gbp_op_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign q_ready = (count != (PTR_W+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

>>> rtl/gbp_back.sv
// ---------------------------------------------------------------------------
// gbp_back
// counter table: read, saturating update, response register, reset sweep
// ---------------------------------------------------------------------------
module gbp_back #(
  parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gbp_pkg::gbp_op_t q_op,
  output logic             q_pop,
  output logic             clear_busy,
  gbp_resp_if.source       resp
);

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam logic [SW-1:0] LAST = SW'(TABLE_ENTRIES - 1);

  logic [1:0]       mem [TABLE_ENTRIES];
  logic [SW-1:0]    clr_addr;
  logic             clr_busy;
  logic [1:0]       rdata;
  logic             w_valid;
  gbp_pkg::gbp_op_t w_op;
  logic             fwd_hit;
  logic [1:0]       fwd_val;
  logic             out_valid;
  logic             out_taken;

  logic [1:0]    cnt;
  logic [1:0]    new_cnt;
  logic          w_write;
  logic          out_free;
  logic          w_done;
  logic          issue;
  logic [SW-1:0] w_slot;
  logic [SW-1:0] r_slot;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;

  assign w_slot = w_op.slot[SW-1:0];
  assign r_slot = q_op.slot[SW-1:0];

  // value written by the previous operation to the same slot wins over the stale read
  assign cnt = fwd_hit ? fwd_val : rdata;

  always_comb begin
    new_cnt = cnt;
    if (w_op.taken) begin
      if (cnt != gbp_pkg::CNT_MAX) begin
        new_cnt = cnt + 2'd1;
      end
    end else if (cnt != gbp_pkg::CNT_MIN) begin
      new_cnt = cnt - 2'd1;
    end
  end

  assign w_write  = w_valid && w_op.is_update && w_op.qual;
  assign out_free = !out_valid || resp.ready;
  assign w_done   = w_valid && (w_op.is_update || out_free);
  assign issue    = q_valid && (!w_valid || w_done) && !clr_busy;
  assign q_pop    = issue;

  assign clear_busy         = clr_busy;
  assign resp.valid         = out_valid;
  assign resp.predict_taken = out_taken;

  assign mem_we    = clr_busy || w_write;
  assign mem_waddr = clr_busy ? clr_addr : w_slot;
  assign mem_wdata = clr_busy ? gbp_pkg::CNT_MIN : new_cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[r_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      w_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        if (clr_addr == LAST) begin
          clr_busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (issue) begin
        w_valid <= 1'b1;
      end else if (w_done) begin
        w_valid <= 1'b0;
      end
      if (w_done && !w_op.is_update) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      w_op    <= q_op;
      fwd_hit <= w_write && (w_slot == r_slot);
      fwd_val <= new_cnt;
    end
    if (w_done && !w_op.is_update) begin
      // non-qualifying predicts answer taken
      out_taken <= w_op.qual ? cnt[1] : 1'b1;
    end
  end

endmodule

>>> rtl/gshare_branch_predictor.sv
// ---------------------------------------------------------------------------
// gshare_branch_predictor
// gshare direction predictor over a table of 2-bit saturating counters
// ---------------------------------------------------------------------------
// usage
//   req  : valid/ready channel of branch items; action selects predict or
//          resolve. a transfer happens on a clock edge with valid and ready high
//   resp : one transfer per predict item, carrying predict_taken, in order;
//          resolve items give no response
//   throughput: one item per cycle while resp.ready is high; front stage,
//          queue and table read/write stage each move one item a cycle
//   path: a predict moves through the front stage, the queue, the table
//          read and the response register before it shows on resp.valid
//   reset: rst synchronous; afterwards the table is swept to zero, one entry
//          per cycle over all TABLE_ENTRIES entries, and req.ready stays low
//          during the sweep
//   stall: while resp is held off, the response register keeps its value,
//          resolves up to the next predict still drain, and the four-entry
//          queue plus front stage absorb items before req.ready drops
// ---------------------------------------------------------------------------
module gshare_branch_predictor #(
  parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_WIDTH   = gbp_pkg::INDEX_WIDTH_DEF,
  parameter int HISTORY_WIDTH = gbp_pkg::HISTORY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gbp_req_if.sink    req,
  gbp_resp_if.source resp
);

  // front to queue
  logic             push;
  gbp_pkg::gbp_op_t push_op;
  logic             q_ready;

  // queue to back
  logic             q_valid;
  gbp_pkg::gbp_op_t q_op;
  logic             q_pop;

  // table sweep in progress, holds off new requests
  logic             clear_busy;

  // history, index forming and slot reduction
  gbp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .INDEX_WIDTH   (INDEX_WIDTH),
    .HISTORY_WIDTH (HISTORY_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .clear_busy (clear_busy),
    .q_ready    (q_ready),
    .push       (push),
    .push_op    (push_op)
  );

  // decouples front from the table so each side can stall alone
  gbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (q_pop)
  );

  // counter table with read-modify-write and response register
  gbp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .resp       (resp)
  );

endmodule

>>> rtl/gbp_checker.sv
// ---------------------------------------------------------------------------
// gbp_checker
// port-level checks for the gshare branch predictor
// ---------------------------------------------------------------------------
module gbp_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_action,
  input logic resp_valid,
  input logic resp_ready,
  input logic resp_taken
);

  // predicts taken in but not yet answered
  logic [3:0] pending;
  logic       pred_in;
  logic       resp_out;

  assign pred_in  = req_valid && req_ready && (req_action == gbp_pkg::ACT_PREDICT);
  assign resp_out = resp_valid && resp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (pred_in && !resp_out) begin
      pending <= pending + 1'b1;
    end else if (resp_out && !pred_in) begin
      pending <= pending - 1'b1;
    end
  end

  // held response keeps its value
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp_taken))
    else $error("response changed while stalled");

  // table sweep follows reset, no request taken right away
  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request ready during table sweep");

  // every response answers an earlier predict
  a_no_orphan_resp: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> pending != 4'd0)
    else $error("response without outstanding predict");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .resp_taken (resp.predict_taken)
);

>>> sim/tb_gshare_branch_predictor.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gshare_branch_predictor
// self-checking bench: drives predict and resolve items over the request
// channel, keeps its own copy of table, history and saved index, and compares
// every predict_taken response against the expected direction, in order
// ---------------------------------------------------------------------------
module tb_gshare_branch_predictor;

  // sizing follows the block's default parameters
  localparam int IDX_W    = gbp_pkg::INDEX_WIDTH_DEF;
  localparam int HIST_W   = gbp_pkg::HISTORY_WIDTH_DEF;
  localparam int TBL_SIZE = gbp_pkg::TABLE_ENTRIES_DEF;

  // stimulus volume and shape
  localparam int ITEMS      = 1100;
  localparam int TAIL_ITEMS = 150;  // last stretch runs with no idling
  localparam int MID_DRAIN  = 500;  // sender waits for all responses here
  localparam int HOT_BRANCHES = 8;

  // one request item as it crosses the channel
  typedef struct packed {
    logic        action;
    logic [31:0] branch_addr;
    logic        is_cond;
    logic        is_call_br;
    logic        is_ret_br;
    logic [7:0]  op_count;
    logic        outcome_taken;
  } branch_item_t;

  // -------------------------------------------------------------------------
  // scoreboard: mirrors the predictor state and holds the pending directions
  // -------------------------------------------------------------------------
  class gshare_scoreboard;
    bit [1:0]        counters [TBL_SIZE];
    bit [HIST_W-1:0] history;
    bit [IDX_W-1:0]  last_index;
    bit              pending_dirs [$];
    int failures, checked, predicts, resolves, updates, saturated_hits;

    function bit qualifying(branch_item_t b);
      return b.is_cond && !b.is_call_br && !b.is_ret_br &&
             (b.op_count >= gbp_pkg::MIN_OPS);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] error: %s", $realtime, msg);
    endfunction

    // accepted request: advance the mirror, queue a direction for predicts
    function void note_branch(branch_item_t b);
      bit [IDX_W-1:0] idx;
      bit [1:0]       cnt;
      if (b.action == gbp_pkg::ACT_PREDICT) begin
        predicts++;
        if (!qualifying(b)) begin
          pending_dirs.push_back(1'b1);
        end else begin
          idx        = b.branch_addr[IDX_W-1:0] ^ history[HIST_W-1 -: IDX_W];
          last_index = idx;
          pending_dirs.push_back(counters[idx][1]);
        end
      end else begin
        resolves++;
        if (qualifying(b)) begin
          updates++;
          cnt = counters[last_index];
          if (b.outcome_taken) begin
            if (cnt != gbp_pkg::CNT_MAX) cnt++;
            else saturated_hits++;
          end else begin
            if (cnt != gbp_pkg::CNT_MIN) cnt--;
            else saturated_hits++;
          end
          counters[last_index] = cnt;
        end
        history = {history[HIST_W-2:0], b.outcome_taken};
      end
    endfunction

    // accepted response: compare with the oldest pending direction
    function void check_response(logic got);
      bit want;
      if (pending_dirs.size() == 0) begin
        flag($sformatf("response predict_taken=%0b with nothing pending", got));
        return;
      end
      want = pending_dirs.pop_front();
      checked++;
      if (got !== want)
        flag($sformatf("response %0d: expected predict_taken=%0b, got %0b",
                       checked, want, got));
    endfunction

    function int pending();
      return pending_dirs.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // clock, reset, channels, block
  // -------------------------------------------------------------------------
  logic clk;
  logic rst;

  gbp_req_if  req ();
  gbp_resp_if resp ();

  gshare_branch_predictor DUT (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  gshare_scoreboard sb = new();

  int sent;     // transfers completed on the request side
  bit tail;     // final stretch: no idling on either side
  bit rx_calm;  // receiver stretch without stalls

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // monitor: both channels sampled at the edge, values as they were before it
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    branch_item_t seen;
    if (!rst) begin
      if (req.valid && req.ready) begin
        seen.action        = req.action;
        seen.branch_addr   = req.branch_addr;
        seen.is_cond       = req.is_cond;
        seen.is_call_br    = req.is_call_br;
        seen.is_ret_br     = req.is_ret_br;
        seen.op_count      = req.op_count;
        seen.outcome_taken = req.outcome_taken;
        sb.note_branch(seen);
      end
      if ($isunknown(resp.valid))
        sb.flag("resp.valid unknown after reset");
      else if (resp.valid && resp.ready)
        sb.check_response(resp.predict_taken);
    end
  end

  // -------------------------------------------------------------------------
  // response side: random stall bursts, none in calm stretches or the tail
  // -------------------------------------------------------------------------
  initial begin : response_sink
    int stall_left;
    stall_left = 0;
    resp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        resp.ready <= 1'b0;
        stall_left--;
      end else begin
        resp.ready <= 1'b1;
        if (!tail && !rx_calm && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 11);
      end
    end
  end

  // -------------------------------------------------------------------------
  // request side tasks; each is entered just after a rising edge
  // -------------------------------------------------------------------------

  // present one item and hold it until the transfer edge
  task automatic drive_branch(input branch_item_t b);
    req.valid         <= 1'b1;
    req.action        <= b.action;
    req.branch_addr   <= b.branch_addr;
    req.is_cond       <= b.is_cond;
    req.is_call_br    <= b.is_call_br;
    req.is_ret_br     <= b.is_ret_br;
    req.op_count      <= b.op_count;
    req.outcome_taken <= b.outcome_taken;
    do @(posedge clk); while (!(req.ready === 1'b1));
    sent++;
  endtask

  task automatic idle_req(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the sender until every queued direction has come back
  task automatic drain_responses();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random gap before an item, skipped in quiet stretches
  task automatic maybe_gap();
    if (!tail && ((sent / 100) % 4 != 3) && $urandom_range(0, 4) == 0)
      idle_req($urandom_range(1, 11));
  endtask

  function automatic branch_item_t make_item(logic act, logic [31:0] addr,
                                             logic cond, logic call, logic ret,
                                             logic [7:0] ops, logic taken);
    branch_item_t b;
    b.action        = act;
    b.branch_addr   = addr;
    b.is_cond       = cond;
    b.is_call_br    = call;
    b.is_ret_br     = ret;
    b.op_count      = ops;
    b.outcome_taken = taken;
    return b;
  endfunction

  // qualifying item with a random operand count of at least two
  function automatic branch_item_t qual_item(logic act, logic [31:0] addr,
                                             logic taken);
    logic [7:0] ops;
    ops = ($urandom_range(0, 3) == 0) ? gbp_pkg::MIN_OPS : 8'($urandom_range(2, 255));
    return make_item(act, addr, 1'b1, 1'b0, 1'b0, ops, taken);
  endfunction

  // item with every field but the action random, qualifying or not
  function automatic branch_item_t noise_item(logic act);
    return make_item(act, $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                     8'($urandom_range(0, 255)), 1'($urandom));
  endfunction

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] hot_addr [HOT_BRANCHES];
    int          hot_bias [HOT_BRANCHES];  // percent taken per hot branch
    int          pick, k;
    logic [31:0] addr;
    logic        taken;
    bit          mid_done;

    sent     = 0;
    tail     = 1'b0;
    rx_calm  = 1'b0;
    mid_done = 1'b0;

    rst                   <= 1'b1;
    req.valid             <= 1'b0;
    req.action            <= gbp_pkg::ACT_PREDICT;
    req.branch_addr       <= '0;
    req.is_cond           <= 1'b0;
    req.is_call_br        <= 1'b0;
    req.is_ret_br         <= 1'b0;
    req.op_count          <= '0;
    req.outcome_taken     <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part; ready stays low through the table sweep, the driver waits
    // resolve with no predict yet works on saved index zero
    drive_branch(make_item(gbp_pkg::ACT_RESOLVE, 32'h0, 1'b1, 1'b0, 1'b0, 8'd2, 1'b1));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h0, 1'b1, 1'b0, 1'b0, 8'd2, 1'b0));
    // walk the counter up into saturation
    repeat (3)
      drive_branch(make_item(gbp_pkg::ACT_RESOLVE, 32'h0, 1'b1, 1'b0, 1'b0, 8'd2, 1'b1));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h0, 1'b1, 1'b0, 1'b0, 8'd3, 1'b1));
    // each disqualifier on a predict answers taken and keeps the saved index
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h1234, 1'b0, 1'b0, 1'b0, 8'd4, 1'b0));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h1234, 1'b1, 1'b1, 1'b0, 8'd4, 1'b0));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h1234, 1'b1, 1'b0, 1'b1, 8'd4, 1'b0));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h1234, 1'b1, 1'b0, 1'b0, 8'd1, 1'b0));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'h1234, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0));
    // non-qualifying resolve only shifts the history
    drive_branch(make_item(gbp_pkg::ACT_RESOLVE, 32'h0, 1'b1, 1'b1, 1'b0, 8'd2, 1'b0));
    // all-ones address and operand count
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
                           8'hFF, 1'b1));
    // walk the counter down into saturation at zero
    repeat (4)
      drive_branch(make_item(gbp_pkg::ACT_RESOLVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
                             8'hFF, 1'b0));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
                           8'hFF, 1'b0));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                           8'hFF, 1'b1));
    drive_branch(make_item(gbp_pkg::ACT_RESOLVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
                           8'hFF, 1'b1));
    drive_branch(make_item(gbp_pkg::ACT_RESOLVE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                           8'hFF, 1'b1));
    drive_branch(make_item(gbp_pkg::ACT_PREDICT, 32'hAAAA_5555, 1'b1, 1'b0, 1'b0,
                           8'd2, 1'b0));
    drain_responses();

    // a few hot branches with strong or weak bias so counters saturate
    for (k = 0; k < HOT_BRANCHES; k++) begin
      hot_addr[k] = $urandom;
      case ($urandom_range(0, 3))
        0:       hot_bias[k] = 5;
        1:       hot_bias[k] = 95;
        2:       hot_bias[k] = 50;
        default: hot_bias[k] = 80;
      endcase
    end

    // random part: mostly predict/resolve pairs, some noise
    while (sent < ITEMS) begin
      tail    = (sent >= ITEMS - TAIL_ITEMS);
      rx_calm = ((sent / 100) % 4 == 1);
      if (!mid_done && sent >= MID_DRAIN) begin
        drain_responses();
        mid_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed pair: qualifying predict, then its resolve
        if ($urandom_range(0, 4) == 0) begin
          addr  = $urandom;
          taken = 1'($urandom);
        end else begin
          k     = $urandom_range(0, HOT_BRANCHES - 1);
          addr  = hot_addr[k];
          taken = ($urandom_range(0, 99) < hot_bias[k]);
        end
        maybe_gap();
        drive_branch(qual_item(gbp_pkg::ACT_PREDICT, addr, 1'($urandom)));
        maybe_gap();
        drive_branch(qual_item(gbp_pkg::ACT_RESOLVE, addr, taken));
      end else if (pick < 85) begin
        // lone resolve, qualifying or not
        maybe_gap();
        if ($urandom_range(0, 1) == 0)
          drive_branch(qual_item(gbp_pkg::ACT_RESOLVE, $urandom, 1'($urandom)));
        else
          drive_branch(noise_item(gbp_pkg::ACT_RESOLVE));
      end else begin
        // lone predict with random fields
        maybe_gap();
        drive_branch(noise_item(gbp_pkg::ACT_PREDICT));
      end
    end
    tail = 1'b1;

    // wind down: all responses back, then a few cycles for strays
    drain_responses();
    repeat (12) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag($sformatf("%0d responses never arrived", sb.pending()));

    $display("run covered %0d transfers: %0d predicts, %0d resolves (%0d updating)",
             sent, sb.predicts, sb.resolves, sb.updates);
    $display("%0d directions checked, %0d updates hit a saturated counter",
             sb.checked, sb.saturated_hits);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", sb.failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gbp_pkg.sv
rtl/gbp_if.sv
rtl/gbp_front.sv
rtl/gbp_queue.sv
rtl/gbp_back.sv
rtl/gshare_branch_predictor.sv
rtl/gbp_checker.sv
sim/tb_gshare_branch_predictor.sv
